// File: hdl/ohlc_bar_ring_window_top_assert.svh
// assertion macros shared by the bar ring window
`ifndef OHLC_BAR_RING_WINDOW_TOP_ASSERT_SVH
`define OHLC_BAR_RING_WINDOW_TOP_ASSERT_SVH

// same-cycle implication check
`define OBRW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obrw: same-cycle check failed");

// next-cycle implication check
`define OBRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obrw: next-cycle check failed");

`endif

// File: hdl/obrw_pkg.sv
`default_nettype none

package obrw_pkg;

    // field widths fixed by the interface
    localparam int PRICE_W  = 32;
    localparam int DATE_W   = 32;
    localparam int VOL_W    = 48;
    localparam int FAC_W    = 32;
    localparam int AGE_W    = 6;
    localparam int CNT_W    = 7;
    localparam int OP_W     = 2;

    // input queue between front and back
    localparam int Q_DEPTH  = 2;

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_SCALE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // fixed point constants
    localparam logic [FAC_W-1:0]   ONE_Q16   = 32'h0001_0000;
    localparam logic [PRICE_W-1:0] PRICE_MAX = 32'h7FFF_FFFF;
    localparam logic [PRICE_W-1:0] PRICE_MIN = 32'h8000_0000;

    // ready threshold after reset
    localparam logic [CNT_W-1:0] THR_RESET = 7'd1;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        K_PUSH,
        K_SCALE,
        K_READ,
        K_CLEAR
    } kind_t;

    // classified word as queued for the back end
    typedef struct packed {
        kind_t                     kind;
        logic                      scale_ok;
        logic [DATE_W-1:0]         bar_date;
        logic signed [PRICE_W-1:0] price_open;
        logic signed [PRICE_W-1:0] price_high;
        logic signed [PRICE_W-1:0] price_low;
        logic signed [PRICE_W-1:0] price_close;
        logic [VOL_W-1:0]          traded_volume;
        logic [FAC_W-1:0]          factor;
        logic [AGE_W-1:0]          age_index;
    } item_t;

    // one stored bar
    typedef struct packed {
        logic [DATE_W-1:0]         date;
        logic signed [PRICE_W-1:0] open_p;
        logic signed [PRICE_W-1:0] high_p;
        logic signed [PRICE_W-1:0] low_p;
        logic signed [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]          volume;
    } bar_t;

    // result word
    typedef struct packed {
        logic                      bar_valid;
        logic [DATE_W-1:0]         out_date;
        logic signed [PRICE_W-1:0] out_open;
        logic signed [PRICE_W-1:0] out_high;
        logic signed [PRICE_W-1:0] out_low;
        logic signed [PRICE_W-1:0] out_close;
        logic [VOL_W-1:0]          out_volume;
        logic signed [PRICE_W-1:0] newest_close;
        logic [DATE_W-1:0]         newest_date;
        logic [CNT_W-1:0]          bar_count;
        logic                      ready_res;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/obrw_ram.sv
`default_nettype none

module obrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/obrw_front.sv
`default_nettype none

module obrw_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [obrw_pkg::OP_W-1:0]           op,
    input  wire logic [obrw_pkg::DATE_W-1:0]         bar_date,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_open,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_high,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_low,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_close,
    input  wire logic [obrw_pkg::VOL_W-1:0]          traded_volume,
    input  wire logic [obrw_pkg::FAC_W-1:0]          factor,
    input  wire logic [obrw_pkg::AGE_W-1:0]          age_index,
    output logic                                     q_valid,
    output obrw_pkg::item_t                          q_item,
    input  wire logic                                q_pop
);

    localparam int QW = $clog2(obrw_pkg::Q_DEPTH);

    typedef logic [QW-1:0] ptr_t;
    typedef logic [QW:0]   fill_t;

    obrw_pkg::item_t q_mem [obrw_pkg::Q_DEPTH];
    obrw_pkg::item_t item_in;

    ptr_t  wr_ptr_reg, wr_ptr_next;
    ptr_t  rd_ptr_reg, rd_ptr_next;
    fill_t fill_reg, fill_next;
    logic  push;

    // classify the incoming word
    always_comb
    begin
        item_in.bar_date      = bar_date;
        item_in.price_open    = price_open;
        item_in.price_high    = price_high;
        item_in.price_low     = price_low;
        item_in.price_close   = price_close;
        item_in.traded_volume = traded_volume;
        item_in.age_index     = age_index;
        item_in.factor        = factor;
        item_in.scale_ok      = (factor != '0) && (factor != obrw_pkg::ONE_Q16);
        case (op)
            obrw_pkg::OP_PUSH:
            begin
                item_in.kind = obrw_pkg::K_PUSH;
                // a zero factor on a push means unity
                if (factor == '0)
                begin
                    item_in.factor = obrw_pkg::ONE_Q16;
                end
            end
            obrw_pkg::OP_SCALE: item_in.kind = obrw_pkg::K_SCALE;
            obrw_pkg::OP_READ:  item_in.kind = obrw_pkg::K_READ;
            default:            item_in.kind = obrw_pkg::K_CLEAR;
        endcase
    end

    // queue control
    assign in_ready = (fill_reg < fill_t'(obrw_pkg::Q_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ptr_t'(obrw_pkg::Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ptr_t'(obrw_pkg::Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// File: hdl/obrw_back.sv
`default_nettype none

`include "ohlc_bar_ring_window_top_assert.svh"

module obrw_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire obrw_pkg::item_t              q_item,
    output logic                              q_pop,
    input  wire logic                         cfg_valid,
    input  wire logic [obrw_pkg::CNT_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output obrw_pkg::res_t                    res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [AW-1:0]              slot_t;
    typedef logic [CW-1:0]              cntw_t;
    typedef logic [AW:0]                idx_t;
    typedef logic [obrw_pkg::AGE_W:0]   sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_SCAN,
        ST_FIN
    } state_t;

    localparam logic signed [47:0] Q_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] Q_MIN = 48'shFFFF_8000_0000;

    // signed price times unsigned factor, full product
    function automatic logic signed [63:0] price_mul(
        input logic signed [obrw_pkg::PRICE_W-1:0] p,
        input logic [obrw_pkg::FAC_W-1:0]          f
    );
        logic signed [64:0] full;
        full = p * $signed({1'b0, f});
        return full[63:0];
    endfunction

    // drop 16 fraction bits (floor) and clamp to 32 bits
    function automatic logic signed [obrw_pkg::PRICE_W-1:0] price_sat(
        input logic signed [63:0] prod
    );
        logic signed [47:0] q;
        q = $signed(prod[63:16]);
        if (q > Q_MAX)
        begin
            return obrw_pkg::PRICE_MAX;
        end
        else if (q < Q_MIN)
        begin
            return obrw_pkg::PRICE_MIN;
        end
        return q[31:0];
    endfunction

    state_t state_reg, state_next;
    slot_t  slot_reg, slot_next;
    cntw_t  count_reg, count_next;
    logic [obrw_pkg::CNT_W-1:0] thr_reg, thr_next;
    obrw_pkg::item_t cur_reg, cur_next;
    logic signed [63:0] po_reg, po_next, ph_reg, ph_next;
    logic signed [63:0] pl_reg, pl_next, pc_reg, pc_next;
    logic [obrw_pkg::DATE_W-1:0] date2_reg, date2_next;
    logic [obrw_pkg::VOL_W-1:0]  vol2_reg, vol2_next;
    slot_t  rd_addr_reg, rd_addr_next;
    logic   rvalid_reg, rvalid_next;
    idx_t   scan_idx_reg, scan_idx_next;
    logic   v1_reg, v1_next, v2_reg, v2_next;
    slot_t  a1_reg, a1_next, a2_reg, a2_next;
    logic signed [obrw_pkg::PRICE_W-1:0] newest_close_reg, newest_close_next;
    logic [obrw_pkg::DATE_W-1:0]         newest_date_reg, newest_date_next;
    obrw_pkg::res_t res_reg, res_next;
    logic   out_valid_reg, out_valid_next;

    logic            out_free;
    slot_t           last_slot;
    slot_t           slot_inc;
    cntw_t           count_inc;
    slot_t           rd_start;
    sum_t            rd_sum;
    sum_t            rd_adj;
    slot_t           head_addr;
    logic            head_rvalid;
    obrw_pkg::bar_t  ram_q;
    logic [$bits(obrw_pkg::bar_t)-1:0] ram_rdata;
    obrw_pkg::bar_t  wr_bar;
    logic            ram_we;
    slot_t           ram_waddr;
    slot_t           ram_raddr;
    logic signed [obrw_pkg::PRICE_W-1:0] mul_o, mul_h, mul_l, mul_c;
    logic [obrw_pkg::FAC_W-1:0]          mul_f;
    logic signed [obrw_pkg::PRICE_W-1:0] sat_o, sat_h, sat_l, sat_c;
    logic signed [obrw_pkg::PRICE_W-1:0] nc_gate;
    logic [obrw_pkg::DATE_W-1:0]         nd_gate;

    // bar store
    obrw_ram #(
        .WIDTH ($bits(obrw_pkg::bar_t)),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_bar),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_q = ram_rdata;

    // ring bookkeeping
    assign out_free  = !out_valid_reg || out_ready;
    assign last_slot = (slot_reg == '0) ? slot_t'(CAPACITY - 1) : slot_reg - 1'b1;
    assign slot_inc  = (slot_reg == slot_t'(CAPACITY - 1)) ? '0 : slot_reg + 1'b1;
    assign count_inc = (count_reg < cntw_t'(CAPACITY)) ? count_reg + 1'b1 : count_reg;

    // age to slot for a read at the queue head
    assign rd_start    = (count_reg < cntw_t'(CAPACITY)) ? '0 : slot_reg;
    assign rd_sum      = sum_t'(rd_start) + sum_t'(q_item.age_index);
    assign rd_adj      = (rd_sum >= sum_t'(CAPACITY)) ? rd_sum - sum_t'(CAPACITY) : rd_sum;
    assign head_addr   = rd_adj[AW-1:0];
    assign head_rvalid = (q_item.age_index < count_reg);

    // multiplier operands: queue head for a push, store word while scanning
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mul_o = q_item.price_open;
            mul_h = q_item.price_high;
            mul_l = q_item.price_low;
            mul_c = q_item.price_close;
            mul_f = q_item.factor;
        end
        else
        begin
            mul_o = ram_q.open_p;
            mul_h = ram_q.high_p;
            mul_l = ram_q.low_p;
            mul_c = ram_q.close_p;
            mul_f = cur_reg.factor;
        end
    end

    // saturate registered products
    assign sat_o = price_sat(po_reg);
    assign sat_h = price_sat(ph_reg);
    assign sat_l = price_sat(pl_reg);
    assign sat_c = price_sat(pc_reg);

    always_comb
    begin
        wr_bar.date    = date2_reg;
        wr_bar.open_p  = sat_o;
        wr_bar.high_p  = sat_h;
        wr_bar.low_p   = sat_l;
        wr_bar.close_p = sat_c;
        wr_bar.volume  = vol2_reg;
    end

    assign ram_waddr = (state_reg == ST_SCAN) ? a2_reg : slot_reg;
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_idx_reg[AW-1:0] :
                       (state_reg == ST_IDLE) ? head_addr : rd_addr_reg;

    assign nc_gate = (count_reg != '0) ? newest_close_reg : '0;
    assign nd_gate = (count_reg != '0) ? newest_date_reg : '0;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        count_next        = count_reg;
        thr_next          = thr_reg;
        cur_next          = cur_reg;
        po_next           = po_reg;
        ph_next           = ph_reg;
        pl_next           = pl_reg;
        pc_next           = pc_reg;
        date2_next        = date2_reg;
        vol2_next         = vol2_reg;
        rd_addr_next      = rd_addr_reg;
        rvalid_next       = rvalid_reg;
        scan_idx_next     = scan_idx_reg;
        v1_next           = v1_reg;
        v2_next           = v2_reg;
        a1_next           = a1_reg;
        a2_next           = a2_reg;
        newest_close_next = newest_close_reg;
        newest_date_next  = newest_date_reg;
        res_next          = res_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        q_pop             = 1'b0;
        ram_we            = 1'b0;

        if (cfg_valid)
        begin
            thr_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                    case (q_item.kind)
                        obrw_pkg::K_PUSH:
                        begin
                            po_next    = price_mul(mul_o, mul_f);
                            ph_next    = price_mul(mul_h, mul_f);
                            pl_next    = price_mul(mul_l, mul_f);
                            pc_next    = price_mul(mul_c, mul_f);
                            date2_next = q_item.bar_date;
                            vol2_next  = q_item.traded_volume;
                            state_next = ST_PUSH;
                        end
                        obrw_pkg::K_READ:
                        begin
                            rd_addr_next = head_addr;
                            rvalid_next  = head_rvalid;
                            state_next   = ST_READ;
                        end
                        obrw_pkg::K_SCALE:
                        begin
                            if (q_item.scale_ok && (count_reg != '0))
                            begin
                                scan_idx_next = '0;
                                v1_next       = 1'b0;
                                v2_next       = 1'b0;
                                state_next    = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        default:
                        begin
                            slot_next  = '0;
                            count_next = '0;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_PUSH:
            begin
                // write and report together so the ring moves exactly once
                if (out_free)
                begin
                    ram_we                = 1'b1;
                    slot_next             = slot_inc;
                    count_next            = count_inc;
                    newest_close_next     = sat_c;
                    newest_date_next      = date2_reg;
                    res_next              = '0;
                    res_next.newest_close = sat_c;
                    res_next.newest_date  = date2_reg;
                    res_next.bar_count    = obrw_pkg::cnt_t'(count_inc);
                    res_next.ready_res    = (obrw_pkg::cnt_t'(count_inc) >= thr_reg);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_READ:
            begin
                // store output is held while the result register is busy
                if (out_free)
                begin
                    res_next = '0;
                    if (rvalid_reg)
                    begin
                        res_next.bar_valid  = 1'b1;
                        res_next.out_date   = ram_q.date;
                        res_next.out_open   = ram_q.open_p;
                        res_next.out_high   = ram_q.high_p;
                        res_next.out_low    = ram_q.low_p;
                        res_next.out_close  = ram_q.close_p;
                        res_next.out_volume = ram_q.volume;
                    end
                    res_next.newest_close = nc_gate;
                    res_next.newest_date  = nd_gate;
                    res_next.bar_count    = obrw_pkg::cnt_t'(count_reg);
                    res_next.ready_res    = (obrw_pkg::cnt_t'(count_reg) >= thr_reg);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue reads over every slot
                if (scan_idx_reg < idx_t'(CAPACITY))
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    v1_next       = 1'b1;
                    a1_next       = scan_idx_reg[AW-1:0];
                end
                else
                begin
                    v1_next = 1'b0;
                end
                // multiply the word just read
                v2_next = v1_reg;
                a2_next = a1_reg;
                if (v1_reg)
                begin
                    po_next    = price_mul(mul_o, mul_f);
                    ph_next    = price_mul(mul_h, mul_f);
                    pl_next    = price_mul(mul_l, mul_f);
                    pc_next    = price_mul(mul_c, mul_f);
                    date2_next = ram_q.date;
                    vol2_next  = ram_q.volume;
                end
                // write back, tracking the newest close
                if (v2_reg)
                begin
                    ram_we = 1'b1;
                    if (a2_reg == last_slot)
                    begin
                        newest_close_next = sat_c;
                    end
                end
                if ((scan_idx_reg == idx_t'(CAPACITY)) && !v1_reg && !v2_reg)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    res_next              = '0;
                    res_next.newest_close = nc_gate;
                    res_next.newest_date  = nd_gate;
                    res_next.bar_count    = obrw_pkg::cnt_t'(count_reg);
                    res_next.ready_res    = (obrw_pkg::cnt_t'(count_reg) >= thr_reg);
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            count_reg        <= '0;
            thr_reg          <= obrw_pkg::THR_RESET;
            cur_reg          <= '0;
            po_reg           <= '0;
            ph_reg           <= '0;
            pl_reg           <= '0;
            pc_reg           <= '0;
            date2_reg        <= '0;
            vol2_reg         <= '0;
            rd_addr_reg      <= '0;
            rvalid_reg       <= 1'b0;
            scan_idx_reg     <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            a1_reg           <= '0;
            a2_reg           <= '0;
            newest_close_reg <= '0;
            newest_date_reg  <= '0;
            res_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            count_reg        <= count_next;
            thr_reg          <= thr_next;
            cur_reg          <= cur_next;
            po_reg           <= po_next;
            ph_reg           <= ph_next;
            pl_reg           <= pl_next;
            pc_reg           <= pc_next;
            date2_reg        <= date2_next;
            vol2_reg         <= vol2_next;
            rd_addr_reg      <= rd_addr_next;
            rvalid_reg       <= rvalid_next;
            scan_idx_reg     <= scan_idx_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            a1_reg           <= a1_next;
            a2_reg           <= a2_next;
            newest_close_reg <= newest_close_next;
            newest_date_reg  <= newest_date_next;
            res_reg          <= res_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // count never passes capacity
    `OBRW_ASSERT_IMPLY(a_cnt_cap, clk, rst_n, 1'b1, count_reg <= cntw_t'(CAPACITY))
    // a reported push grows the count by one unless the ring is full
    `OBRW_ASSERT_NEXT(a_push_count, clk, rst_n, (state_reg == ST_PUSH) && out_free, (count_reg == $past(count_reg) + 1'b1) || (count_reg == cntw_t'(CAPACITY)))
    // the scan pipeline is empty before its result goes out
    `OBRW_ASSERT_IMPLY(a_scan_drain, clk, rst_n, state_reg == ST_FIN, !v1_reg && !v2_reg)

endmodule

`default_nettype wire

// File: hdl/ohlc_bar_ring_window_top.sv
// Ring of CAPACITY price bars with push, rescale, read-by-age and clear words.
// Input words enter a two-entry queue, so the input side keeps accepting while a
// result waits in the output register. A push multiplies, then saturates and
// writes; a read goes through the registered read port of the bar RAM; a
// rescale walks over all slots through the one read and one write port of the
// bar RAM, and input words queue up behind it meanwhile. The ready threshold
// register is written through the cfg port, which is always ready.

`default_nettype none

module ohlc_bar_ring_window_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [obrw_pkg::CNT_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [obrw_pkg::OP_W-1:0]           op,
    input  wire logic [obrw_pkg::DATE_W-1:0]         bar_date,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_open,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_high,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_low,
    input  wire logic signed [obrw_pkg::PRICE_W-1:0] price_close,
    input  wire logic [obrw_pkg::VOL_W-1:0]          traded_volume,
    input  wire logic [obrw_pkg::FAC_W-1:0]          factor,
    input  wire logic [obrw_pkg::AGE_W-1:0]          age_index,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     bar_valid,
    output logic [obrw_pkg::DATE_W-1:0]              out_date,
    output logic signed [obrw_pkg::PRICE_W-1:0]      out_open,
    output logic signed [obrw_pkg::PRICE_W-1:0]      out_high,
    output logic signed [obrw_pkg::PRICE_W-1:0]      out_low,
    output logic signed [obrw_pkg::PRICE_W-1:0]      out_close,
    output logic [obrw_pkg::VOL_W-1:0]               out_volume,
    output logic signed [obrw_pkg::PRICE_W-1:0]      newest_close,
    output logic [obrw_pkg::DATE_W-1:0]              newest_date,
    output logic [obrw_pkg::CNT_W-1:0]               bar_count,
    output logic                                     ready_res
);

    logic            q_valid;
    logic            q_pop;
    obrw_pkg::item_t q_item;
    obrw_pkg::res_t  res;

    // threshold writes are taken at any time
    assign cfg_ready = 1'b1;

    // front: accept and classify words
    obrw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .bar_date      (bar_date),
        .price_open    (price_open),
        .price_high    (price_high),
        .price_low     (price_low),
        .price_close   (price_close),
        .traded_volume (traded_volume),
        .factor        (factor),
        .age_index     (age_index),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // back: ring store and result register
    obrw_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // result word fields
    assign bar_valid    = res.bar_valid;
    assign out_date     = res.out_date;
    assign out_open     = res.out_open;
    assign out_high     = res.out_high;
    assign out_low      = res.out_low;
    assign out_close    = res.out_close;
    assign out_volume   = res.out_volume;
    assign newest_close = res.newest_close;
    assign newest_date  = res.newest_date;
    assign bar_count    = res.bar_count;
    assign ready_res    = res.ready_res;

endmodule

`default_nettype wire
